@@ design/lctb_pkg.sv @@
// shared types and constants for the layered color tint blend core
// no dependencies
`default_nettype none

package lctb_pkg;

  localparam int MAX_LAYERS_DEF = 3;
  localparam int NUM_SLOTS      = 3;

  localparam int PIX_W     = 32;
  localparam int CH_W      = 8;
  localparam int COLOR_W   = 24;
  localparam int LEVEL_W   = 7;
  localparam int COUNT_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [LEVEL_W-1:0] LEVEL_CAP  = 7'd100;
  localparam logic [CH_W-1:0]    FULL_ALPHA = 8'd255;
  localparam logic [CH_W-1:0]    UNITY      = 8'd128;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_COLOR_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_LEVEL_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_COLOR_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_LEVEL_1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_COLOR_2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_LEVEL_2 = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_TINT_COLOR [NUM_SLOTS] =
    '{REG_TINT_COLOR_0, REG_TINT_COLOR_1, REG_TINT_COLOR_2};
  localparam logic [CFG_IDX_W-1:0] REG_TINT_LEVEL [NUM_SLOTS] =
    '{REG_TINT_LEVEL_0, REG_TINT_LEVEL_1, REG_TINT_LEVEL_2};

  typedef struct packed {
    logic               active;
    logic [COLOR_W-1:0] color;
    logic [LEVEL_W-1:0] level;
  } layer_cfg_t;

endpackage

`default_nettype wire

@@ design/layered_color_tint_blend_core.sv @@
// top level of the layered color tint blend core: config registers and cell chain
// depends on lctb_pkg and lctb_cell
//
// channel  | dir | payload
// s_axis   | in  | tdata[31:0] in_pixel (a 31:24, r 23:16, g 15:8, b 7:0)
// m_axis   | out | tdata[31:0] out_pixel, same packing
// cfg      | in  | cfg_index selects register, cfg_data written when cfg_we
//
// one pixel per cycle sustained while m_axis_tready stays high
// each layer cell has a level scaling register and a blend register
// rst clears valid bits and config registers
// tready runs back through every stage in the same cycle; empty stages keep accepting
`default_nettype none

module layered_color_tint_blend_core #(
  parameter int MAX_LAYERS = lctb_pkg::MAX_LAYERS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [lctb_pkg::PIX_W-1:0]         s_axis_tdata,  // in_pixel
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [lctb_pkg::PIX_W-1:0]              m_axis_tdata,  // out_pixel
  input  wire logic                               cfg_we,
  input  wire logic [lctb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lctb_pkg::CFG_DAT_W-1:0]     cfg_data
);

  logic [lctb_pkg::COUNT_W-1:0] layer_count;
  logic [lctb_pkg::COLOR_W-1:0] tint_color [MAX_LAYERS];
  logic [lctb_pkg::LEVEL_W-1:0] tint_level [MAX_LAYERS];

  logic                         vld [MAX_LAYERS+1];
  logic                         rdy [MAX_LAYERS+1];
  logic [lctb_pkg::PIX_W-1:0]   pix [MAX_LAYERS+1];
  logic [lctb_pkg::PIX_W-1:0]   last_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= '0;
      for (int k = 0; k < MAX_LAYERS; k++) begin
        tint_color[k] <= '0;
        tint_level[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == lctb_pkg::REG_LAYER_COUNT) begin
        layer_count <= cfg_data[lctb_pkg::COUNT_W-1:0];
      end
      for (int k = 0; k < MAX_LAYERS; k++) begin
        if (cfg_index == lctb_pkg::REG_TINT_COLOR[k]) begin
          tint_color[k] <= cfg_data[lctb_pkg::COLOR_W-1:0];
        end
        if (cfg_index == lctb_pkg::REG_TINT_LEVEL[k]) begin
          tint_level[k] <= cfg_data[lctb_pkg::LEVEL_W-1:0];
        end
      end
    end
  end

  assign vld[0]        = s_axis_tvalid;
  assign pix[0]        = s_axis_tdata;
  assign s_axis_tready = rdy[0];

  for (genvar k = 0; k < MAX_LAYERS; k++) begin : g_cell
    lctb_pkg::layer_cfg_t cfg;

    assign cfg.active = layer_count > lctb_pkg::COUNT_W'(k);
    assign cfg.color  = tint_color[k];
    assign cfg.level  = tint_level[k];

    lctb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_pix    (pix[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_pix   (pix[k+1])
    );
  end

  assign last_pix          = pix[MAX_LAYERS];
  assign m_axis_tvalid     = vld[MAX_LAYERS];
  assign rdy[MAX_LAYERS]   = m_axis_tready;
  assign m_axis_tdata      = (last_pix[31:24] == '0) ? '0 : last_pix;

endmodule

`default_nettype wire

@@ design/lctb_cell.sv @@
// one tint layer of the blend chain: level scaling stage then blend stage
// depends on lctb_pkg
`default_nettype none

module lctb_cell (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire lctb_pkg::layer_cfg_t           cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lctb_pkg::PIX_W-1:0]     in_pix,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [lctb_pkg::PIX_W-1:0]          out_pix
);

  localparam int CH   = lctb_pkg::CH_W;
  localparam int LW   = lctb_pkg::LEVEL_W;
  localparam int PW   = 2 * CH;

  function automatic logic [CH-1:0] blend(input logic [CH-1:0] ch,
                                          input logic [CH-1:0] tint,
                                          input logic [LW-1:0] lvl);
    logic [CH-1:0] inv;
    logic [PW-1:0] sum;
    begin
      inv = lctb_pkg::UNITY - {1'b0, lvl};
      sum = (PW'(ch) * PW'(inv)) + (PW'({1'b0, lvl}) * PW'(tint));
      blend = sum[PW-2:LW];
    end
  endfunction

  logic              valid1;
  logic [31:0]       pix1;
  logic [LW-1:0]     lvl1;
  logic              ready1;
  logic              ready2;

  logic [LW-1:0]     lvl_sat;
  logic [PW-2:0]     lvl_prod;
  logic [LW-1:0]     lvl_scaled;
  logic [CH-1:0]     alpha;

  assign alpha    = in_pix[31:24];
  assign lvl_sat  = (cfg.level > lctb_pkg::LEVEL_CAP) ? lctb_pkg::LEVEL_CAP : cfg.level;
  assign lvl_prod = (PW-1)'(alpha) * (PW-1)'(lvl_sat);

  always_comb begin
    if (!cfg.active) begin
      lvl_scaled = '0;
    end else if (alpha == lctb_pkg::FULL_ALPHA) begin
      lvl_scaled = lvl_sat;
    end else begin
      lvl_scaled = lvl_prod[PW-2:CH];
    end
  end

  assign ready2   = !out_valid || out_ready;
  assign ready1   = !valid1 || ready2;
  assign in_ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (ready1) begin
      valid1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      pix1 <= in_pix;
      lvl1 <= lvl_scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= valid1;
    end
  end

  // pixel red pairs with tint bits 7:0, pixel blue with tint bits 23:16
  always_ff @(posedge clk) begin
    if (ready2 && valid1) begin
      out_pix[31:24] <= pix1[31:24];
      out_pix[23:16] <= blend(pix1[23:16], cfg.color[7:0], lvl1);
      out_pix[15:8]  <= blend(pix1[15:8], cfg.color[15:8], lvl1);
      out_pix[7:0]   <= blend(pix1[7:0], cfg.color[23:16], lvl1);
    end
  end

endmodule

`default_nettype wire
